>>> src/mco_pkg.sv
// Shared constants and types for the midpoint circle outline generator.
package mco_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;
    localparam int OUT_W           = 14;
    localparam int COLOR_W         = 8;
    localparam int POINTS          = 8;
    localparam int IDX_W           = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int STEP_INC        = 2;

    typedef enum logic
    {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } color_t;

endpackage

>>> src/mco_front.sv
// Front end: accepts load and step beats, keeps the octant walk, queues step descriptors.
module mco_front
    import mco_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int DESC_W      = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 4 * COLOR_W + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic [COLOR_W-1:0]     red,
    input  logic [COLOR_W-1:0]     green,
    input  logic [COLOR_W-1:0]     blue,
    input  logic [COLOR_W-1:0]     alpha,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [DESC_W-1:0]      q_data
);

    localparam int WALK_W = RADIUS_BITS + 1;
    localparam int STEP_W = RADIUS_BITS + 3;
    localparam int ERR_W  = RADIUS_BITS + 4;

    localparam logic signed [WALK_W-1:0] ONE_W  = WALK_W'(1);
    localparam logic signed [ERR_W-1:0]  ONE_E  = ERR_W'(1);
    localparam logic [STEP_W-1:0]        ONE_S  = STEP_W'(1);
    localparam logic [STEP_W-1:0]        INC_S  = STEP_W'(STEP_INC);

    logic [COORD_BITS-1:0]    center_col_reg, center_col_next;
    logic [COORD_BITS-1:0]    center_row_reg, center_row_next;
    logic [RADIUS_BITS-1:0]   radius_reg, radius_next;
    logic signed [WALK_W-1:0] walk_x_reg, walk_x_next;
    logic signed [WALK_W-1:0] walk_y_reg, walk_y_next;
    logic [STEP_W-1:0]        step_tx_reg, step_tx_next;
    logic [STEP_W-1:0]        step_ty_reg, step_ty_next;
    logic signed [ERR_W-1:0]  error_reg, error_next;
    color_t                   color_reg, color_next;
    logic                     active_reg, active_next;

    logic                     accept;
    logic                     is_step;
    logic                     fire;
    logic signed [WALK_W-1:0] x1, y1;
    logic [STEP_W-1:0]        tx1, ty1;
    logic signed [ERR_W-1:0]  e1, e2;
    logic signed [ERR_W-1:0]  two_r;
    logic signed [ERR_W-1:0]  two_r_in;
    logic                     done;

    // Accept a beat whenever the queue has room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_step  = (req_t'(req_type) == REQ_STEP);
    assign fire     = accept && is_step && active_reg && (walk_x_reg >= walk_y_reg);

    assign two_r    = $signed({3'b000, radius_reg, 1'b0});
    assign two_r_in = $signed({3'b000, radius, 1'b0});

    // Advance the walk by one octant position
    always_comb
    begin
        y1  = walk_y_reg;
        ty1 = step_ty_reg;
        e1  = error_reg;
        if (error_reg <= 0)
        begin
            y1  = walk_y_reg + ONE_W;
            e1  = error_reg + $signed({1'b0, step_ty_reg});
            ty1 = step_ty_reg + INC_S;
        end
        x1  = walk_x_reg;
        tx1 = step_tx_reg;
        e2  = e1;
        if (e1 > 0)
        begin
            x1  = walk_x_reg - ONE_W;
            tx1 = step_tx_reg + INC_S;
            e2  = e1 + $signed({1'b0, tx1}) - two_r;
        end
        done = (x1 < y1);
    end

    // Hand the current position to the back end
    assign q_push = fire;
    assign q_data = {done, color_reg, walk_y_reg, walk_x_reg, center_row_reg, center_col_reg};

    // Select next walk state
    always_comb
    begin
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        radius_next     = radius_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        step_tx_next    = step_tx_reg;
        step_ty_next    = step_ty_reg;
        error_next      = error_reg;
        color_next      = color_reg;
        active_next     = active_reg;
        if (accept && !is_step)
        begin
            center_col_next = center_x;
            center_row_next = center_y;
            radius_next     = radius;
            walk_x_next     = $signed({1'b0, radius}) - ONE_W;
            walk_y_next     = '0;
            step_tx_next    = ONE_S;
            step_ty_next    = ONE_S;
            error_next      = ONE_E - two_r_in;
            color_next      = '{red: red, green: green, blue: blue, alpha: alpha};
            active_next     = (radius != '0);
        end
        else if (fire)
        begin
            walk_x_next  = x1;
            walk_y_next  = y1;
            step_tx_next = tx1;
            step_ty_next = ty1;
            error_next   = e2;
            active_next  = !done;
        end
    end

    // Hold walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            radius_reg     <= '0;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            step_tx_reg    <= '0;
            step_ty_reg    <= '0;
            error_reg      <= '0;
            color_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            radius_reg     <= radius_next;
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            step_tx_reg    <= step_tx_next;
            step_ty_reg    <= step_ty_next;
            error_reg      <= error_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
        end
    end

endmodule

>>> src/mco_queue.sv
// Short descriptor queue between the front and back ends.
module mco_queue
    import mco_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + ONE_PTR;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + ONE_PTR;
        end
        if (push && !pop)
        begin
            count_next = count_reg + ONE_CNT;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ONE_CNT;
        end
    end

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/mco_back.sv
// Back end: expands one step descriptor into eight symmetric points, one beat per cycle while out_stall is low.
module mco_back
    import mco_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int DESC_W      = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 4 * COLOR_W + 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  logic [DESC_W-1:0]       q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic [COLOR_W-1:0]      out_red,
    output logic [COLOR_W-1:0]      out_green,
    output logic [COLOR_W-1:0]      out_blue,
    output logic [COLOR_W-1:0]      out_alpha,
    output logic                    last_of_step,
    output logic                    circle_done
);

    localparam int WALK_W  = RADIUS_BITS + 1;
    // Unsigned center plus walk offset needs a carry bit and a sign bit
    localparam int SUM_W   = ((COORD_BITS > WALK_W) ? COORD_BITS : WALK_W) + 2;
    localparam int CX_LO   = 0;
    localparam int CY_LO   = COORD_BITS;
    localparam int X_LO    = 2 * COORD_BITS;
    localparam int Y_LO    = X_LO + WALK_W;
    localparam int COL_LO  = Y_LO + WALK_W;
    localparam int DONE_B  = COL_LO + 4 * COLOR_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

    logic [DESC_W-1:0]       desc_reg, desc_next;
    logic                    desc_valid_reg, desc_valid_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    logic signed [OUT_W-1:0] point_x_reg, point_y_reg;
    color_t                  color_out_reg;
    logic                    last_reg, done_reg;
    logic                    out_valid_reg, out_valid_next;

    logic                    issue;
    logic                    last_pt;
    logic signed [SUM_W-1:0] cx, cy, wx, wy, a, b, px, py;
    color_t                  color_in;

    // Unpack the current descriptor
    assign cx = $signed({{(SUM_W - COORD_BITS){1'b0}}, desc_reg[CX_LO +: COORD_BITS]});
    assign cy = $signed({{(SUM_W - COORD_BITS){1'b0}}, desc_reg[CY_LO +: COORD_BITS]});
    assign wx = $signed({{(SUM_W - WALK_W){desc_reg[X_LO + WALK_W - 1]}},
                         desc_reg[X_LO +: WALK_W]});
    assign wy = $signed({{(SUM_W - WALK_W){desc_reg[Y_LO + WALK_W - 1]}},
                         desc_reg[Y_LO +: WALK_W]});
    assign color_in = color_t'(desc_reg[COL_LO +: 4 * COLOR_W]);

    // Pick the octant: upper half swaps x and y, bit 1 mirrors the column, bit 0 the row
    always_comb
    begin
        a  = idx_reg[2] ? wy : wx;
        b  = idx_reg[2] ? wx : wy;
        px = idx_reg[1] ? (cx - a) : (cx + a);
        py = idx_reg[0] ? (cy + b) : (cy - b);
    end

    assign issue   = desc_valid_reg && (!out_valid_reg || !out_stall);
    assign last_pt = (idx_reg == LAST_IDX);
    assign q_pop   = q_valid && (!desc_valid_reg || (issue && last_pt));

    // Advance the point counter and refill the descriptor
    always_comb
    begin
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg;
        idx_next        = idx_reg;
        if (issue)
        begin
            idx_next = last_pt ? '0 : idx_reg + ONE_IDX;
            if (last_pt)
            begin
                desc_valid_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            desc_next       = q_data;
            desc_valid_next = 1'b1;
        end
        out_valid_next = issue || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold descriptor and output payload
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        if (issue)
        begin
            point_x_reg   <= OUT_W'(px);
            point_y_reg   <= OUT_W'(py);
            color_out_reg <= color_in;
            last_reg      <= last_pt;
            done_reg      <= desc_reg[DONE_B];
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign out_red      = color_out_reg.red;
    assign out_green    = color_out_reg.green;
    assign out_blue     = color_out_reg.blue;
    assign out_alpha    = color_out_reg.alpha;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

>>> src/midpoint_circle_outline.sv
// Top level of the midpoint circle outline generator.
// A step beat's points pass the queue, the descriptor register and the output register.
// A step yields eight points, one point per cycle while out_stall is low, set by the single
// output register of the back end. Loads are taken whenever the queue has room. A 2-deep
// descriptor queue lets the front take further beats while points drain.
// Reset (rst_n, async low) clears the walk state and queue; nothing is drawn until a load.
module midpoint_circle_outline
    import mco_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [RADIUS_BITS-1:0]  radius,
    input  logic [COLOR_W-1:0]      red,
    input  logic [COLOR_W-1:0]      green,
    input  logic [COLOR_W-1:0]      blue,
    input  logic [COLOR_W-1:0]      alpha,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic [COLOR_W-1:0]      out_red,
    output logic [COLOR_W-1:0]      out_green,
    output logic [COLOR_W-1:0]      out_blue,
    output logic [COLOR_W-1:0]      out_alpha,
    output logic                    last_of_step,
    output logic                    circle_done
);

    localparam int DESC_W = 2 * COORD_BITS + 2 * (RADIUS_BITS + 1) + 4 * COLOR_W + 1;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_not_empty;
    logic [DESC_W-1:0] q_wdata;
    logic [DESC_W-1:0] q_rdata;

    mco_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .DESC_W      (DESC_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    mco_queue #(
        .DATA_W (DESC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    mco_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .DESC_W      (DESC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

endmodule

>>> src/mco_checker.sv
// Port-level assertions for the circle outline generator, bound to the top level.
module mco_checker
    import mco_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] point_x,
    input  logic signed [OUT_W-1:0] point_y,
    input  logic [COLOR_W-1:0]      out_red,
    input  logic [COLOR_W-1:0]      out_alpha,
    input  logic                    last_of_step,
    input  logic                    circle_done
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y))
        else $error("stalled output beat changed");

    // Emit the eight points of a step without gaps
    a_step_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_step |=> out_valid)
        else $error("gap inside the points of one step");

    // Keep red, alpha and the done flag fixed across one step
    a_step_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_step |=>
            $stable(out_red) && $stable(out_alpha) && $stable(circle_done))
        else $error("step attributes changed between points");

endmodule

bind midpoint_circle_outline mco_checker u_mco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .out_red      (out_red),
    .out_alpha    (out_alpha),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
);

>>> tb/sv/tb.sv
// Testbench for midpoint_circle_outline: predicted points checked beat by beat.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mco_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int RW           = RADIUS_BITS_DEF;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 134;

    typedef struct
    {
        req_t            kind;
        logic [CW-1:0]   cx;
        logic [CW-1:0]   cy;
        logic [RW-1:0]   rad;
        color_t          col;
    } request_t;

    typedef struct
    {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        color_t                  col;
        logic                    last;
        logic                    done;
    } point_t;

    // Octant walk predictor plus the queue of points it still expects
    class outline_tracker;
        int     errors;
        point_t expected_points[$];
        int     ctr_col;
        int     ctr_row;
        int     rad_r;
        int     wx;
        int     wy;
        int     tx;
        int     ty;
        int     err;
        color_t color;
        bit     drawing;

        function new();
            errors  = 0;
            ctr_col = 0;
            ctr_row = 0;
            rad_r   = 0;
            wx      = 0;
            wy      = 0;
            tx      = 0;
            ty      = 0;
            err     = 0;
            color   = '0;
            drawing = 1'b0;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // Update the walk for one accepted request beat and queue its points
        function void take_request(request_t r);
            int     px[POINTS];
            int     py[POINTS];
            point_t p;
            bit     done;
            if (r.kind == REQ_LOAD)
            begin
                ctr_col = int'(r.cx);
                ctr_row = int'(r.cy);
                rad_r   = int'(r.rad);
                color   = r.col;
                wx      = rad_r - 1;
                wy      = 0;
                tx      = 1;
                ty      = 1;
                err     = tx - STEP_INC * rad_r;
                drawing = (wx >= wy);
                return;
            end
            if (!drawing || wx < wy)
                return;

            px[0] = ctr_col + wx;  py[0] = ctr_row - wy;
            px[1] = ctr_col + wx;  py[1] = ctr_row + wy;
            px[2] = ctr_col - wx;  py[2] = ctr_row - wy;
            px[3] = ctr_col - wx;  py[3] = ctr_row + wy;
            px[4] = ctr_col + wy;  py[4] = ctr_row - wx;
            px[5] = ctr_col + wy;  py[5] = ctr_row + wx;
            px[6] = ctr_col - wy;  py[6] = ctr_row - wx;
            px[7] = ctr_col - wy;  py[7] = ctr_row + wx;

            // advance the error term: row step first, then column step
            if (err <= 0)
            begin
                wy  = wy + 1;
                err = err + ty;
                ty  = ty + STEP_INC;
            end
            if (err > 0)
            begin
                wx  = wx - 1;
                tx  = tx + STEP_INC;
                err = err + tx - STEP_INC * rad_r;
            end
            if (wx < wy)
                drawing = 1'b0;
            done = !drawing;

            for (int k = 0; k < POINTS; k++)
            begin
                p.x    = px[k][OUT_W-1:0];
                p.y    = py[k][OUT_W-1:0];
                p.col  = color;
                p.last = (k == POINTS - 1);
                p.done = done;
                expected_points.push_back(p);
            end
        endfunction

        function void compare_field(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match one accepted point beat against the oldest expectation
        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d",
                         $time, got.x, got.y);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            compare_field("point_x", want.x, got.x);
            compare_field("point_y", want.y, got.y);
            compare_field("out_red", {8'd0, want.col.red}, {8'd0, got.col.red});
            compare_field("out_green", {8'd0, want.col.green}, {8'd0, got.col.green});
            compare_field("out_blue", {8'd0, want.col.blue}, {8'd0, got.col.blue});
            compare_field("out_alpha", {8'd0, want.col.alpha}, {8'd0, got.col.alpha});
            compare_field("last_of_step", {15'd0, want.last}, {15'd0, got.last});
            compare_field("circle_done", {15'd0, want.done}, {15'd0, got.done});
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    req_type = 1'b0;
    logic [CW-1:0]           center_x = '0;
    logic [CW-1:0]           center_y = '0;
    logic [RW-1:0]           radius = '0;
    logic [COLOR_W-1:0]      red = '0;
    logic [COLOR_W-1:0]      green = '0;
    logic [COLOR_W-1:0]      blue = '0;
    logic [COLOR_W-1:0]      alpha = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic [COLOR_W-1:0]      out_red;
    logic [COLOR_W-1:0]      out_green;
    logic [COLOR_W-1:0]      out_blue;
    logic [COLOR_W-1:0]      out_alpha;
    logic                    last_of_step;
    logic                    circle_done;

    outline_tracker tracker = new();
    int             send_idle_pct = 15;
    int             recv_idle_pct = 52;
    int             quiet_cycles = 0;
    int             items_sent = 0;

    midpoint_circle_outline i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the point channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Observe both channels and feed the tracker
    always @(posedge clk)
    begin
        point_t got;
        request_t req;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                req.kind = req_t'(req_type);
                req.cx   = center_x;
                req.cy   = center_y;
                req.rad  = radius;
                req.col  = {red, green, blue, alpha};
                tracker.take_request(req);
            end
            if (out_valid && !out_stall)
            begin
                got.x    = point_x;
                got.y    = point_y;
                got.col  = {out_red, out_green, out_blue, out_alpha};
                got.last = last_of_step;
                got.done = circle_done;
                tracker.check_point(got);
            end
        end
    end

    // Drop the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request beat, after a random gap, and hold it until taken
    task automatic send_beat(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.kind;
        center_x <= r.cx;
        center_y <= r.cy;
        radius   <= r.rad;
        red      <= r.col.red;
        green    <= r.col.green;
        blue     <= r.col.blue;
        alpha    <= r.col.alpha;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load(input int cx, input int cy, input int rad, input int c);
        request_t r;
        r.kind = REQ_LOAD;
        r.cx   = CW'(cx);
        r.cy   = CW'(cy);
        r.rad  = RW'(rad);
        r.col  = color_t'(c);
        send_beat(r);
    endtask

    // Step beats carry random payload that the block must ignore
    task automatic send_steps(input int count);
        request_t r;
        for (int i = 0; i < count; i++)
        begin
            r.kind = REQ_STEP;
            r.cx   = CW'($urandom);
            r.cy   = CW'($urandom);
            r.rad  = RW'($urandom);
            r.col  = color_t'($urandom);
            send_beat(r);
        end
    endtask

    // Mostly whole circles with random content, some cut short, some noise
    task automatic run_random(input int target);
        request_t r;
        int       rad;
        int       steps;
        int       stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                case ($urandom_range(19))
                    0:       rad = 0;
                    1, 2:    rad = $urandom_range((1 << RW) - 1);
                    default: rad = $urandom_range(1, 24);
                endcase
                send_load($urandom, $urandom, rad, $urandom);
                if (rad > 24)
                    steps = $urandom_range(1, 10);
                else
                    steps = rad - rad / 4 + $urandom_range(0, 2);
                if (steps > 1 && $urandom_range(99) < 15)
                    steps = $urandom_range(1, steps - 1);
                send_steps(steps);
            end
            else
            begin
                r.kind = req_t'($urandom_range(1));
                r.cx   = CW'($urandom);
                r.cy   = CW'($urandom);
                r.rad  = ($urandom_range(3) == 0) ? RW'($urandom) : RW'($urandom_range(0, 24));
                r.col  = color_t'($urandom);
                send_beat(r);
            end
        end
    endtask

    initial
    begin
        // Hold reset at the start, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step after reset draws nothing
        send_steps(1);
        // smallest circle at the origin, then a step after the walk ended
        send_load(0, 0, 1, 32'h0000_0000);
        send_steps(2);
        // zero radius draws nothing
        send_load((1 << CW) - 1, (1 << CW) - 1, 0, 32'hFFFF_FFFF);
        send_steps(1);
        // largest radius at the far corner, partial walk
        send_load((1 << CW) - 1, (1 << CW) - 1, (1 << RW) - 1, 32'hFFFF_FFFF);
        send_steps(3);
        // largest radius at the origin, then a load abandons the walk
        send_load(0, 0, (1 << RW) - 1, 32'h1234_5678);
        send_steps(2);
        send_load(2048, 2048, 5, 32'hA55A_C33C);
        send_steps(5);

        // Random: sender idles lightly, receiver heavily
        run_random(PHASE_ITEMS);
        // swap the idling
        send_idle_pct = 52;
        recv_idle_pct = 15;
        run_random(PHASE_ITEMS);
        // full speed both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);

        // Drain every expected point, then watch for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
